// ----- design/koe_pkg.sv -----
// Shared types and constants for the Euler-Cromer orbit unit.
`default_nettype none
package koe_pkg;
  localparam int FRAC_BITS = 16;
  localparam logic [3:0] IMPULSE_GAIN = 4'd10;
  localparam logic [38:0] QCAP = {39{1'b1}};

  localparam logic [2:0] REG_GM = 3'd0;
  localparam logic [2:0] REG_DT = 3'd1;
  localparam logic [2:0] REG_STEPS = 3'd2;
  localparam logic [2:0] REG_IMP = 3'd3;
  localparam logic [2:0] REG_PX = 3'd4;
  localparam logic [2:0] REG_PY = 3'd5;
  localparam logic [2:0] REG_VX = 3'd6;
  localparam logic [2:0] REG_VY = 3'd7;

  localparam logic [1:0] FAULT_OK = 2'd0;
  localparam logic [1:0] FAULT_SAT = 2'd1;
  localparam logic [1:0] FAULT_ZERO = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SQRT, S_G1, S_G2, S_G3, S_GX, S_GY, S_IMP,
    S_VX, S_PX, S_VY, S_PY, S_DONE
  } state_t;

  typedef struct packed {
    logic start_sqrt;
    logic start_div;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Saturate a signed 66-bit value to 32 bits.
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647) r = {1'b1, 32'h7fffffff};
    else if (v < -66'sd2147483648) r = {1'b1, 32'h80000000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- design/koe_if.sv -----
// Valid/ready stream interface.
`default_nettype none
interface koe_if #(parameter int W = 1) ();
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/koe_sqrt.sv -----
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none
module koe_sqrt import koe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic [31:0]      root,
  output unit_sts_t        sts
);
  logic [63:0] rem;
  logic [31:0] q;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [65:0] trial;
  logic [63:0] src;

  assign trial = {rem, src[63:62]} - {32'd0, q, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        rem  <= '0;
        q    <= '0;
        src  <= radicand;
      end else if (busy) begin
        src <= {src[61:0], 2'b00};
        if (!trial[65]) begin
          rem <= trial[63:0];
          q   <= {q[30:0], 1'b1};
        end else begin
          rem <= {rem[61:0], src[63:62]};
          q   <= {q[30:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = q;
  assign sts.busy = busy;
  assign sts.done = done;
endmodule
`default_nettype wire

// ----- design/koe_div.sv -----
// Restoring divider, 56-bit dividend by 32-bit divisor, one quotient bit per cycle.
`default_nettype none
module koe_div import koe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [55:0] dividend,
  input  wire logic [31:0] divisor,
  output logic [55:0]      quot,
  output unit_sts_t        sts
);
  logic [55:0] q;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem[31:0], q[55]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        q    <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (!diff[32]) begin
          rem <= diff;
          q   <= {q[54:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[54:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd55) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;
  assign sts.busy = busy;
  assign sts.done = done;
endmodule
`default_nettype wire

// ----- design/kepler_orbit_euler_cromer_unit.sv -----
// Top level of the Euler-Cromer orbit integrator.
//
//  channel | dir | payload                                   | accepted
//  in_ch   | in  | restart (1 bit)                           | valid & ready
//  out_ch  | out | pos/vel/acc x,y (32 bit each), fault (2)  | valid & ready
//  cfg     | in  | cfg_we, cfg_index (3), cfg_data (32)      | cfg_we
//
// Each step runs a check, a square root, three divisions on the shared
// divider, and six multiply-accumulate steps (seven with the impulse), one
// multiply per cycle. A step at zero radius skips the divisions. An item
// runs step_count steps.
// The unit takes one item at a time and is not ready until the result
// transfer finishes; a stalled output holds the unit in its done state.
// Reset is synchronous and loads the register defaults and initial state.
`default_nettype none
module kepler_orbit_euler_cromer_unit import koe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  koe_if.sink              in_ch,
  koe_if.source            out_ch
);
  // Configuration registers.
  logic [30:0] gm;
  logic [16:0] dt;
  logic [15:0] step_count;
  logic        impulse_on;
  logic [31:0] init_pos_x, init_pos_y, init_vel_x, init_vel_y;

  // Orbit state.
  logic signed [31:0] position_x, position_y, velocity_x, velocity_y;
  logic signed [31:0] accel_x_last, accel_y_last;
  logic [15:0] steps_left;
  logic        sat, zero;

  // Step scratch.
  logic [31:0] r;
  logic [38:0] g2, g3;
  logic signed [65:0] ax, ay;

  state_t state, state_next;
  unit_ctl_t ctl;
  unit_sts_t sq_sts, dv_sts;
  logic [31:0] sq_root;
  logic [55:0] dv_quot;
  logic [55:0] dv_in;
  logic [38:0] dv_cap;
  logic [31:0] div_by;
  logic [63:0] rad;
  logic [31:0] ux, uy;

  assign ux = position_x[31] ? 32'(-position_x) : position_x;
  assign uy = position_y[31] ? 32'(-position_y) : position_y;
  assign rad = 64'(ux) * 64'(ux) + 64'(uy) * 64'(uy);

  // The next division chains straight off the capped quotient that just finished,
  // and the first one divides by the root in the cycle it arrives.
  assign dv_cap = (dv_quot > 56'(QCAP)) ? QCAP : dv_quot[38:0];
  assign div_by = (state == S_SQRT) ? sq_root : r;

  always_comb begin
    case (state)
      S_SQRT:  dv_in = {9'd0, gm, 16'd0};
      S_G1:    dv_in = {1'b0, dv_cap, 16'd0};
      S_G2:    dv_in = {1'b0, dv_cap, 16'd0};
      default: dv_in = '0;
    endcase
  end

  koe_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(ctl.start_sqrt), .radicand(rad),
    .root(sq_root), .sts(sq_sts)
  );

  koe_div u_div (
    .clk(clk), .rst(rst), .start(ctl.start_div), .dividend(dv_in),
    .divisor(div_by), .quot(dv_quot), .sts(dv_sts)
  );

  // Shared multiplier: 41 x 33 signed/unsigned operand pairs, one per cycle.
  logic signed [40:0] mul_a;
  logic [32:0] mul_b;
  logic signed [74:0] mul_p;
  logic [73:0] mul_mag;
  logic signed [65:0] mulq;
  logic [32:0] s_ax, s_ay;
  always_comb begin
    case (state)
      S_GX:    begin mul_a = 41'(g3); mul_b = {1'b0, ux}; end
      S_GY:    begin mul_a = 41'(g3); mul_b = {1'b0, uy}; end
      S_IMP:   begin
        mul_a = (g2 * IMPULSE_GAIN > 43'(QCAP)) ? 41'(QCAP) : 41'(g2 * IMPULSE_GAIN);
        mul_b = 33'(dt);
      end
      S_VX:    begin mul_a = 41'($signed(s_ax[31:0])); mul_b = 33'(dt); end
      S_VY:    begin mul_a = 41'(ay); mul_b = 33'(dt); end
      S_PX:    begin mul_a = 41'(velocity_x); mul_b = 33'(dt); end
      default: begin mul_a = 41'(velocity_y); mul_b = 33'(dt); end
    endcase
    mul_mag = mul_a[40] ? 74'(-mul_a) * 74'(mul_b) : 74'(mul_a) * 74'(mul_b);
    mul_p   = 75'(mul_mag >> FRAC_BITS);
    mulq    = mul_a[40] ? -66'(mul_p) : 66'(mul_p);
  end

  logic imp_cap;
  assign imp_cap = (g2 * IMPULSE_GAIN) > 43'(QCAP);

  // Gravity magnitude capped at 2^32.
  logic [65:0] gmag;
  logic        gcap;
  assign gcap = mul_mag[73:FRAC_BITS] > 58'h100000000;
  assign gmag = gcap ? 66'h100000000 : 66'(mul_mag[73:FRAC_BITS]);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_ch.valid) state_next = S_CHECK;
      S_CHECK: state_next = (steps_left == 16'd0) ? S_DONE : S_SQRT;
      S_SQRT:  if (sq_sts.done) state_next = (sq_root == 32'd0) ? S_VX : S_G1;
      S_G1:    if (dv_sts.done) state_next = S_G2;
      S_G2:    if (dv_sts.done) state_next = S_G3;
      S_G3:    if (dv_sts.done) state_next = S_GX;
      S_GX:    state_next = S_GY;
      S_GY:    state_next = impulse_on ? S_IMP : S_VX;
      S_IMP:   state_next = S_VX;
      S_VX:    state_next = S_PX;
      S_PX:    state_next = S_VY;
      S_VY:    state_next = S_PY;
      S_PY:    state_next = S_CHECK;
      S_DONE:  if (out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    ctl.start_sqrt = 1'b0;
    ctl.start_div  = 1'b0;
    in_ch.ready    = 1'b0;
    out_ch.valid   = 1'b0;
    case (state)
      S_IDLE:  in_ch.ready = 1'b1;
      S_CHECK: ctl.start_sqrt = (steps_left != 16'd0);
      S_SQRT:  ctl.start_div = sq_sts.done && (sq_root != 32'd0);
      S_G1:    ctl.start_div = dv_sts.done;
      S_G2:    ctl.start_div = dv_sts.done;
      S_DONE:  out_ch.valid = 1'b1;
      default: ;
    endcase
  end

  assign out_ch.data = {position_x, position_y, velocity_x, velocity_y,
                        accel_x_last, accel_y_last,
                        zero ? FAULT_ZERO : (sat ? FAULT_SAT : FAULT_OK)};

  logic [32:0] s_v;
  always_comb begin
    s_ax = sat32(ax);
    s_ay = sat32(ay);
    case (state)
      S_VX:    s_v = sat32(66'(velocity_x) + mulq);
      S_PX:    s_v = sat32(66'(position_x) + mulq);
      S_VY:    s_v = sat32(66'(velocity_y) + mulq);
      default: s_v = sat32(66'(position_y) + mulq);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      gm <= 31'd2584635; dt <= 17'd655; step_count <= 16'd10; impulse_on <= 1'b0;
      init_pos_x <= 32'd65536; init_pos_y <= 32'd65536;
      init_vel_x <= 32'd65536; init_vel_y <= 32'd0;
      position_x <= 32'sd65536; position_y <= 32'sd65536;
      velocity_x <= 32'sd65536; velocity_y <= 32'sd0;
      accel_x_last <= '0; accel_y_last <= '0;
      steps_left <= '0; sat <= 1'b0; zero <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_GM:    gm <= cfg_data[30:0];
          REG_DT:    dt <= cfg_data[16:0];
          REG_STEPS: step_count <= cfg_data[15:0];
          REG_IMP:   impulse_on <= cfg_data[0];
          REG_PX:    init_pos_x <= cfg_data;
          REG_PY:    init_pos_y <= cfg_data;
          REG_VX:    init_vel_x <= cfg_data;
          REG_VY:    init_vel_y <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_ch.valid) begin
          steps_left <= step_count;
          sat <= 1'b0;
          zero <= 1'b0;
          if (in_ch.data[0]) begin
            position_x <= init_pos_x; position_y <= init_pos_y;
            velocity_x <= init_vel_x; velocity_y <= init_vel_y;
            accel_x_last <= '0; accel_y_last <= '0;
          end
        end
        S_SQRT: if (sq_sts.done) begin
          r <= sq_root;
          ax <= '0;
          ay <= '0;
          if (sq_root == 32'd0) zero <= 1'b1;
        end
        S_G1: if (dv_sts.done) begin
          if (dv_quot > 56'(QCAP)) begin g2 <= QCAP; sat <= 1'b1; end
          else g2 <= dv_quot[38:0];
        end
        S_G2: if (dv_sts.done) begin
          if (dv_quot > 56'(QCAP)) begin g2 <= QCAP; sat <= 1'b1; end
          else g2 <= dv_quot[38:0];
        end
        S_G3: if (dv_sts.done) begin
          if (dv_quot > 56'(QCAP)) begin g3 <= QCAP; sat <= 1'b1; end
          else g3 <= dv_quot[38:0];
        end
        S_GX: begin
          ax <= position_x[31] ? gmag : -gmag;
          if (gcap) sat <= 1'b1;
        end
        S_GY: begin
          ay <= position_y[31] ? gmag : -gmag;
          if (gcap) sat <= 1'b1;
        end
        S_IMP: begin
          ay <= ay + mulq;
          if (imp_cap) sat <= 1'b1;
        end
        S_VX: begin
          ax <= 66'($signed(s_ax[31:0]));
          ay <= 66'($signed(s_ay[31:0]));
          accel_x_last <= s_ax[31:0];
          accel_y_last <= s_ay[31:0];
          velocity_x <= s_v[31:0];
          if (s_v[32] || s_ax[32] || s_ay[32]) sat <= 1'b1;
        end
        S_PX: begin position_x <= s_v[31:0]; if (s_v[32]) sat <= 1'b1; end
        S_VY: begin velocity_y <= s_v[31:0]; if (s_v[32]) sat <= 1'b1; end
        S_PY: begin
          position_y <= s_v[31:0];
          if (s_v[32]) sat <= 1'b1;
          steps_left <= steps_left - 16'd1;
        end
        default: ;
      endcase
    end
  end

  // The two arithmetic units never run at the same time.
  a_units_excl: assert property (@(posedge clk) disable iff (rst)
    !(sq_sts.busy && dv_sts.busy)) else $error("sqrt and divider overlap");
  // The divider only starts with a nonzero divisor.
  a_div_nz: assert property (@(posedge clk) disable iff (rst)
    ctl.start_div |-> (state == S_SQRT ? sq_root != 32'd0 : r != 32'd0))
    else $error("divide by zero radius");
  // A finished result stays offered until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped");
endmodule
`default_nettype wire
